// ===== design/bdq_pkg.sv =====
// shared constants, types and index helpers for the bounded deque
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 6;
  localparam int VAL_W = 32;
  localparam int LIMIT_MAX = (DEPTH < 32) ? DEPTH : 32;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_POP     = 3'd2,
    OP_RD_HEAD = 3'd3,
    OP_RD_TAIL = 3'd4,
    OP_PURGE   = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_READ,
    S_PURGE
  } state_e;

  // circular slot: (head + off) mod DEPTH, both below DEPTH
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] r;
    if (head == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = head - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== design/bdq_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/bounded_deque_with_even_purge_top.sv =====
// bounded deque top level: control sequencer around the entry memory
`timescale 1ns / 1ps
// One request is taken at a rising edge with start high and busy low. Its results
// follow on the result ports, one cycle each, marked by result_valid_o; they cannot
// be held off, so take every strobed cycle. Append, insert, failures and unknown
// opcodes give their result from execute; a pop goes through execute and pop-wait,
// as the entry memory has a registered read. A readout of n entries gives one
// result per cycle after execute issues the first read; a purge of n entries gives
// its single result once all n are read. Both walk the entries through the single
// memory read port. The next request can be taken at the edge that ends the cycle
// holding the final result. Capacity is written through the cfg channel, which is
// always ready; the user must do so only while the block is idle (not enforced).
module bounded_deque_with_even_purge_top
  import bdq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              opcode_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic                    ok_o,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic [CAP_W-1:0]        entry_count_o,
  output logic                    last_o
);

  state_e           state_q, state_d;
  opcode_e          op_q;
  logic [VAL_W-1:0] val_q;
  logic [CAP_W-1:0] cap_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] kept_q, kept_d;

  logic             strobe_q, strobe_d;
  logic             ok_q, ok_d;
  logic [VAL_W-1:0] oval_q, oval_d;
  logic [CAP_W-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [VAL_W-1:0] rdata;

  logic [CMP_W-1:0] limit;
  logic [CNT_W-1:0] idx_nxt;
  logic [CNT_W-1:0] kept_nxt;
  logic [CNT_W-1:0] rd_off;
  logic             accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign limit = (CMP_W'(cap_q) > CMP_W'(LIMIT_MAX)) ? CMP_W'(LIMIT_MAX) : CMP_W'(cap_q);

  bdq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cap_q    <= CAP_RESET;
      head_q   <= '0;
      occ_q    <= '0;
      idx_q    <= '0;
      kept_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
      kept_q   <= kept_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_e'(opcode_i);
      val_q <= item_value_i;
    end
    ok_q   <= ok_d;
    oval_q <= oval_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    occ_d    = occ_q;
    idx_d    = idx_q;
    kept_d   = kept_q;
    strobe_d = 1'b0;
    ok_d     = ok_q;
    oval_d   = oval_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = val_q;
    re       = 1'b0;
    raddr    = '0;
    idx_nxt  = idx_q + CNT_W'(1);
    kept_nxt = kept_q + CNT_W'(rdata[0]);
    // walk offset of the next read: forward from head or backward from tail
    if (state_q == S_EXEC) begin
      idx_nxt = '0;
    end
    rd_off = (op_q == OP_RD_TAIL) ? (occ_q - CNT_W'(1) - idx_nxt) : idx_nxt;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        // failure result by default
        state_d  = S_IDLE;
        strobe_d = 1'b1;
        ok_d     = 1'b0;
        oval_d   = '0;
        cnt_d    = CAP_W'(occ_q);
        last_d   = 1'b1;
        unique case (op_q) inside
          OP_APPEND, OP_INSERT: begin
            if (CMP_W'(occ_q) < limit) begin
              we = 1'b1;
              if (op_q == OP_APPEND) begin
                waddr = slot(head_q, IDX_W'(occ_q));
              end else begin
                waddr  = slot_prev(head_q);
                head_d = slot_prev(head_q);
              end
              occ_d = occ_q + CNT_W'(1);
              ok_d  = 1'b1;
              cnt_d = CAP_W'(occ_q + CNT_W'(1));
            end
          end
          OP_POP, OP_RD_HEAD, OP_RD_TAIL, OP_PURGE: begin
            if (occ_q != '0) begin
              strobe_d = 1'b0;
              re       = 1'b1;
              raddr    = slot(head_q, IDX_W'(rd_off));
              idx_d    = '0;
              kept_d   = '0;
              if (op_q == OP_POP) begin
                state_d = S_POP_WAIT;
              end else if (op_q == OP_PURGE) begin
                state_d = S_PURGE;
              end else begin
                state_d = S_READ;
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_POP_WAIT: begin
        state_d  = S_IDLE;
        strobe_d = 1'b1;
        ok_d     = 1'b1;
        oval_d   = rdata;
        cnt_d    = CAP_W'(occ_q - CNT_W'(1));
        last_d   = 1'b1;
        head_d   = slot(head_q, IDX_W'(1));
        occ_d    = occ_q - CNT_W'(1);
      end

      S_READ: begin
        strobe_d = 1'b1;
        ok_d     = 1'b1;
        oval_d   = rdata;
        cnt_d    = CAP_W'(occ_q);
        last_d   = (idx_nxt == occ_q);
        if (idx_nxt == occ_q) begin
          state_d = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = slot(head_q, IDX_W'(rd_off));
          idx_d = idx_nxt;
        end
      end

      S_PURGE: begin
        // survivors move down to the kept position, always behind the read pointer
        if (rdata[0]) begin
          we     = 1'b1;
          waddr  = slot(head_q, IDX_W'(kept_q));
          wdata  = rdata;
        end
        kept_d = kept_nxt;
        if (idx_nxt == occ_q) begin
          state_d  = S_IDLE;
          occ_d    = kept_nxt;
          strobe_d = 1'b1;
          ok_d     = 1'b1;
          oval_d   = '0;
          cnt_d    = CAP_W'(kept_nxt);
          last_d   = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = slot(head_q, IDX_W'(rd_off));
          idx_d = idx_nxt;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign result_valid_o = strobe_q;
  assign ok_o           = ok_q;
  assign out_value_o    = oval_q;
  assign entry_count_o  = cnt_q;
  assign last_o         = last_q;

endmodule

// ===== dv/bounded_deque_with_even_purge_top_tb.sv =====
// self-checking testbench for the bounded deque with even purge
`timescale 1ns / 1ps
module bounded_deque_with_even_purge_top_tb;
  import bdq_pkg::*;

  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_DIR_ROWS = 20;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] data;
    logic [CAP_W-1:0] entries;
    logic             last;
  } deque_result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [VAL_W-1:0] val;
    logic             typed;
    logic             exp_ok;
    logic [CAP_W-1:0] exp_entries;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              opcode_i;
  logic signed [VAL_W-1:0] item_value_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CAP_W-1:0]        cfg_data_i;
  logic                    result_valid_o;
  logic                    ok_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic [CAP_W-1:0]        entry_count_o;
  logic                    last_o;

  logic [VAL_W-1:0] mdl_mem [DEPTH];
  int               mdl_head;
  int               mdl_count;
  logic [CAP_W-1:0] mdl_cap;

  deque_result_t awaited_results[$];
  int            fail_count;
  int            idle_cycles;
  bit            no_gaps;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{OP_POP,      32'h0000_0000, 1'b1, 1'b0, 6'd0},
    '{OP_RD_HEAD,  32'h0000_0000, 1'b1, 1'b0, 6'd0},
    '{OP_RD_TAIL,  32'h0000_0000, 1'b1, 1'b0, 6'd0},
    '{OP_PURGE,    32'h0000_0000, 1'b1, 1'b0, 6'd0},
    '{OP_UNDEF_LO, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0},
    '{OP_UNDEF_HI, 32'h0000_0000, 1'b1, 1'b0, 6'd0},
    '{OP_APPEND,   32'h7FFF_FFFF, 1'b1, 1'b1, 6'd1},
    '{OP_INSERT,   32'h8000_0000, 1'b1, 1'b1, 6'd2},
    '{OP_APPEND,   32'hFFFF_FFFF, 1'b1, 1'b1, 6'd3},
    '{OP_INSERT,   32'h0000_0000, 1'b1, 1'b1, 6'd4},
    '{OP_APPEND,   32'h0000_0002, 1'b1, 1'b1, 6'd5},
    '{OP_INSERT,   32'hFFFF_FFFE, 1'b1, 1'b1, 6'd6},
    '{OP_APPEND,   32'h0000_0003, 1'b1, 1'b1, 6'd7},
    '{OP_RD_HEAD,  32'h0000_0000, 1'b0, 1'b0, 6'd0},
    '{OP_RD_TAIL,  32'h0000_0000, 1'b0, 1'b0, 6'd0},
    '{OP_UNDEF_LO, 32'h0000_0000, 1'b1, 1'b0, 6'd7},
    '{OP_PURGE,    32'h0000_0000, 1'b0, 1'b0, 6'd0},
    '{OP_RD_HEAD,  32'h0000_0000, 1'b0, 1'b0, 6'd0},
    '{OP_POP,      32'h0000_0000, 1'b0, 1'b0, 6'd0},
    '{OP_INSERT,   32'h5555_5555, 1'b0, 1'b0, 6'd0}
  };

  bounded_deque_with_even_purge_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .item_value_i   (item_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .out_value_o    (out_value_o),
    .entry_count_o  (entry_count_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int ring_slot(input int off);
    return (mdl_head + off) % DEPTH;
  endfunction

  function automatic int usable_capacity();
    return (int'(mdl_cap) > LIMIT_MAX) ? LIMIT_MAX : int'(mdl_cap);
  endfunction

  function automatic void expect_result(input logic ok, input logic [VAL_W-1:0] data,
                                        input logic last);
    deque_result_t r;
    r.ok      = ok;
    r.data    = data;
    r.entries = CAP_W'(mdl_count);
    r.last    = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_deque_op(input logic [2:0] op, input logic [VAL_W-1:0] val);
    int               n;
    int               kept;
    int               off;
    logic [VAL_W-1:0] v;
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (mdl_count >= usable_capacity()) begin
          expect_result(1'b0, '0, 1'b1);
        end else begin
          if (op == OP_APPEND) begin
            mdl_mem[ring_slot(mdl_count)] = val;
          end else begin
            mdl_head = (mdl_head + DEPTH - 1) % DEPTH;
            mdl_mem[mdl_head] = val;
          end
          mdl_count++;
          expect_result(1'b1, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (mdl_count == 0) begin
          expect_result(1'b0, '0, 1'b1);
        end else begin
          v = mdl_mem[ring_slot(0)];
          mdl_head = ring_slot(1);
          mdl_count--;
          expect_result(1'b1, v, 1'b1);
        end
      end
      OP_RD_HEAD, OP_RD_TAIL: begin
        if (mdl_count == 0) begin
          expect_result(1'b0, '0, 1'b1);
        end else begin
          n = mdl_count;
          for (int i = 0; i < n; i++) begin
            off = (op == OP_RD_HEAD) ? i : (n - 1 - i);
            expect_result(1'b1, mdl_mem[ring_slot(off)], i == n - 1);
          end
        end
      end
      OP_PURGE: begin
        if (mdl_count == 0) begin
          expect_result(1'b0, '0, 1'b1);
        end else begin
          kept = 0;
          for (int i = 0; i < mdl_count; i++) begin
            v = mdl_mem[ring_slot(i)];
            if (v[0]) begin
              mdl_mem[ring_slot(kept)] = v;
              kept++;
            end
          end
          mdl_count = kept;
          expect_result(1'b1, '0, 1'b1);
        end
      end
      default: begin
        expect_result(1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] random_item_value();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return VAL_W'($urandom_range(0, 15));
      3: return -VAL_W'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] random_opcode(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 40) return OP_APPEND;
      if (r < 75) return OP_INSERT;
      if (r < 80) return OP_POP;
      if (r < 86) return OP_RD_HEAD;
      if (r < 92) return OP_RD_TAIL;
      if (r < 95) return OP_PURGE;
    end else begin
      if (r < 8)  return OP_APPEND;
      if (r < 16) return OP_INSERT;
      if (r < 60) return OP_POP;
      if (r < 72) return OP_RD_HEAD;
      if (r < 84) return OP_RD_TAIL;
      if (r < 95) return OP_PURGE;
    end
    return (r[0]) ? OP_UNDEF_HI : OP_UNDEF_LO;
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [VAL_W-1:0] val);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      no_gaps = ~no_gaps;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    item_value_i <= val;
    do @(posedge clk_i); while (busy);
    apply_deque_op(op, val);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0 || busy);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mdl_cap = cap;
  endtask

  always @(posedge clk_i) begin
    deque_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: ok %0d out_value %0d entry_count %0d last %0d",
               ok_o, out_value_o, entry_count_o, last_o);
        fail_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (ok_o !== exp_r.ok) begin
          $error("ok: expected %0d, actual %0d", exp_r.ok, ok_o);
          fail_count++;
        end
        if (out_value_o !== exp_r.data) begin
          $error("out_value: expected %0d, actual %0d", $signed(exp_r.data), out_value_o);
          fail_count++;
        end
        if (entry_count_o !== exp_r.entries) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.entries, entry_count_o);
          fail_count++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, last_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAIL bounded_deque_with_even_purge_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_caps [NUM_PHASES];
    int               n_items;
    bit               filling;
    logic [2:0]       op;

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    opcode_i     <= '0;
    item_value_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    fail_count  = 0;
    idle_cycles = 0;
    no_gaps     = 1'b0;
    mdl_head    = 0;
    mdl_count   = 0;
    mdl_cap     = CAP_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      mdl_mem[i] = '0;
    end
    phase_caps = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd3, 6'd20,
                   CAP_W'($urandom_range(0, 63)), 6'd32};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      send_request(dir_rows[r].op, dir_rows[r].val);
      if (dir_rows[r].typed) begin
        awaited_results[awaited_results.size() - 1] =
          '{dir_rows[r].exp_ok, '0, dir_rows[r].exp_entries, 1'b1};
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      n_items = 20 + 2 * ((int'(phase_caps[p]) > 32) ? 32 : int'(phase_caps[p]));
      filling = 1'b1;
      for (int k = 0; k < n_items; k++) begin
        if (mdl_count >= usable_capacity()) begin
          filling = 1'b0;
        end else if (mdl_count == 0) begin
          filling = 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
          filling = ~filling;
        end
        op = random_opcode(filling);
        send_request(op, random_item_value());
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS bounded_deque_with_even_purge_top");
    end else begin
      $display("FAIL bounded_deque_with_even_purge_top");
    end
    $finish;
  end

endmodule
